@@ hdl/rtbt_pkg.sv @@
// rtbt_pkg: types and constants shared by the retransmit timer table.
// Depends on nothing; rtbt_cfg_regs, rtbt_mem, rtbt_ctrl and the top use it by scoped names.
`default_nettype none

package rtbt_pkg;

  // timer value: initial interval (20 bits) shifted by up to 15 retries
  localparam int TIME_W  = 36;
  localparam int RETRY_W = 4;
  localparam int CNT_W   = 5;
  // results reported per tick at most
  localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd16;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_ACK    = 2'd2,
    OP_DISARM = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_ARMED      = 3'd1,
    ACT_WAKE       = 3'd2,
    ACT_DISARM_ERR = 3'd3,
    ACT_RETRANSMIT = 3'd4,
    ACT_ABORT      = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    CFG_INITIAL_INTERVAL = 2'd0,
    CFG_SCAN_STEP        = 2'd1,
    CFG_MAX_RETRIES      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CTRL,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [19:0]        initial_interval;
    logic [19:0]        scan_step;
    logic [RETRY_W-1:0] max_retries;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [TIME_W-1:0]  tl;
    logic [RETRY_W-1:0] rt;
  } entry_t;

  typedef struct packed {
    logic [3:0]         conn_out;
    act_t               action;
    logic [RETRY_W-1:0] retry_count;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/rtbt_in_if.sv @@
// rtbt_in_if: command word channel (valid/ready) into the timer table.
// No dependencies.
`default_nettype none

interface rtbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] conn;
  logic       send_buffer_empty;

  modport source (output valid, operation, conn, send_buffer_empty, input ready);
  modport sink   (input valid, operation, conn, send_buffer_empty, output ready);
endinterface

`default_nettype wire

@@ hdl/rtbt_out_if.sv @@
// rtbt_out_if: result word channel (valid/ready) out of the timer table.
// No dependencies.
`default_nettype none

interface rtbt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] conn_out;
  logic [2:0] action;
  logic [3:0] retry_count;
  logic       last;

  modport source (output valid, conn_out, action, retry_count, last, input ready);
  modport sink   (input valid, conn_out, action, retry_count, last, output ready);
endinterface

`default_nettype wire

@@ hdl/rtbt_cfg_regs.sv @@
// rtbt_cfg_regs: configuration registers of the timer table.
// Depends on rtbt_pkg.
`default_nettype none

module rtbt_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [19:0]   cfg_data,
  output rtbt_pkg::cfg_t     cfg
);

  rtbt_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_interval <= 20'd200000;
      cfg_r.scan_step        <= 20'd100000;
      cfg_r.max_retries      <= 4'd3;
    end else if (cfg_we) begin
      case (rtbt_pkg::cfg_idx_t'(cfg_index))
        rtbt_pkg::CFG_INITIAL_INTERVAL: cfg_r.initial_interval <= cfg_data;
        rtbt_pkg::CFG_SCAN_STEP:        cfg_r.scan_step        <= cfg_data;
        rtbt_pkg::CFG_MAX_RETRIES:      cfg_r.max_retries      <= cfg_data[3:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ hdl/rtbt_mem.sv @@
// rtbt_mem: per-connection timer entries, one write and one registered read port.
// Per-entry valid bits make never-written entries read as zero. Depends on rtbt_pkg.
`default_nettype none

module rtbt_mem #(
  parameter int NUM_CONN = 16,
  parameter int AW       = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [AW-1:0]   raddr,
  output rtbt_pkg::entry_t     rdata,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire rtbt_pkg::entry_t wdata
);

  rtbt_pkg::entry_t mem [NUM_CONN];
  logic [NUM_CONN-1:0] vld_r;
  rtbt_pkg::entry_t    rdata_r;
  logic                rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

@@ hdl/rtbt_ctrl.sv @@
// rtbt_ctrl: sequencer for the timer table: read-modify-write of one entry per
// control word, a scan over all entries per tick, and the output register.
// Depends on rtbt_pkg, rtbt_in_if, rtbt_out_if.
`default_nettype none

module rtbt_ctrl #(
  parameter int NUM_CONN = 16,
  parameter int AW       = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  rtbt_in_if.sink            in_s,
  rtbt_out_if.source         out_s,
  input  wire rtbt_pkg::cfg_t   cfg,
  output logic [AW-1:0]      raddr,
  input  wire rtbt_pkg::entry_t rdata,
  output logic               we,
  output logic [AW-1:0]      waddr,
  output rtbt_pkg::entry_t   wdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CONN - 1);

  rtbt_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]               idx_r, idx_nxt;
  rtbt_pkg::op_t               op_r, op_nxt;
  logic [3:0]                  conn_r, conn_nxt;
  logic                        sbe_r, sbe_nxt;
  logic                        inr_r, inr_nxt;
  logic [rtbt_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        pend_vld_r, pend_vld_nxt;
  rtbt_pkg::result_t           pend_r, pend_nxt;
  logic                        out_vld_r, out_vld_nxt;
  rtbt_pkg::result_t           out_r, out_nxt;

  logic in_acc, in_rng, out_free;
  logic expire, report, need_push, stall;
  rtbt_pkg::entry_t  scan_e;
  rtbt_pkg::act_t    scan_act;
  rtbt_pkg::entry_t  ctl_e;
  rtbt_pkg::result_t ctl_res;
  logic [rtbt_pkg::RETRY_W-1:0] rt_inc;

  assign in_acc   = in_s.valid && in_s.ready;
  assign in_rng   = 32'(in_s.conn) < 32'(NUM_CONN);
  assign out_free = !out_vld_r || out_s.ready;

  // tick datapath on the entry under idx_r
  always_comb begin
    rt_inc   = rdata.rt + 4'd1;
    expire   = rdata.en && (rdata.tl <= rtbt_pkg::TIME_W'(cfg.scan_step));
    scan_e   = rdata;
    scan_act = rtbt_pkg::ACT_RETRANSMIT;
    if (!expire) begin
      scan_e.tl = rdata.tl - rtbt_pkg::TIME_W'(cfg.scan_step);
    end else if (rdata.rt >= cfg.max_retries) begin
      scan_e.en = 1'b0;
      scan_e.tl = '0;
      scan_act  = rtbt_pkg::ACT_ABORT;
    end else begin
      scan_e.rt = rt_inc;
      scan_e.tl = rtbt_pkg::TIME_W'(cfg.initial_interval) << rt_inc;
    end
    report    = expire && (cnt_r < rtbt_pkg::MAX_RESULTS);
    need_push = report && pend_vld_r;
    stall     = need_push && !out_free;
  end

  // control word datapath on the entry under idx_r
  always_comb begin
    ctl_e   = rdata;
    ctl_res = '{conn_out: conn_r, action: rtbt_pkg::ACT_NONE,
                retry_count: rdata.rt, last: 1'b1};
    case (op_r)
      rtbt_pkg::OP_ARM: begin
        if (!rdata.en) begin
          ctl_e.en = 1'b1;
          ctl_e.rt = '0;
        end
        ctl_e.tl            = rtbt_pkg::TIME_W'(cfg.initial_interval);
        ctl_res.action      = rtbt_pkg::ACT_ARMED;
        ctl_res.retry_count = ctl_e.rt;
      end
      rtbt_pkg::OP_ACK: begin
        if (sbe_r && rdata.en) begin
          ctl_e.en       = 1'b0;
          ctl_res.action = rtbt_pkg::ACT_WAKE;
        end
      end
      rtbt_pkg::OP_DISARM: begin
        ctl_e.en       = 1'b0;
        ctl_res.action = rdata.en ? rtbt_pkg::ACT_WAKE : rtbt_pkg::ACT_DISARM_ERR;
      end
      default: ;
    endcase
    if (!inr_r) begin
      ctl_res.retry_count = '0;
      ctl_res.action      = rtbt_pkg::ACT_NONE;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtbt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (rtbt_pkg::op_t'(in_s.operation) == rtbt_pkg::OP_TICK) ?
                      rtbt_pkg::ST_SCAN : rtbt_pkg::ST_CTRL;
        end
      end
      rtbt_pkg::ST_CTRL: begin
        if (out_free) state_nxt = rtbt_pkg::ST_IDLE;
      end
      rtbt_pkg::ST_SCAN: begin
        if (!stall && idx_r == LAST_IDX) state_nxt = rtbt_pkg::ST_FLUSH;
      end
      rtbt_pkg::ST_FLUSH: begin
        if (!pend_vld_r || out_free) state_nxt = rtbt_pkg::ST_IDLE;
      end
      default: state_nxt = rtbt_pkg::ST_IDLE;
    endcase
  end

  // outputs and register updates
  always_comb begin
    in_s.ready   = (state_r == rtbt_pkg::ST_IDLE);
    idx_nxt      = idx_r;
    op_nxt       = op_r;
    conn_nxt     = conn_r;
    sbe_nxt      = sbe_r;
    inr_nxt      = inr_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_s.ready ? 1'b0 : out_vld_r;
    out_nxt      = out_r;
    raddr        = idx_r;
    we           = 1'b0;
    waddr        = idx_r;
    wdata        = scan_e;
    case (state_r)
      rtbt_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = rtbt_pkg::op_t'(in_s.operation);
          conn_nxt = in_s.conn;
          sbe_nxt  = in_s.send_buffer_empty;
          inr_nxt  = in_rng;
          cnt_nxt  = '0;
          if (rtbt_pkg::op_t'(in_s.operation) == rtbt_pkg::OP_TICK || !in_rng) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = AW'(in_s.conn);
          end
          raddr = idx_nxt;
        end
      end
      rtbt_pkg::ST_CTRL: begin
        if (out_free) begin
          we          = inr_r;
          wdata       = ctl_e;
          out_vld_nxt = 1'b1;
          out_nxt     = ctl_res;
        end
      end
      rtbt_pkg::ST_SCAN: begin
        if (!stall) begin
          we = rdata.en;
          if (need_push) begin
            out_vld_nxt = 1'b1;
            out_nxt     = pend_r;
          end
          if (report) begin
            pend_vld_nxt = 1'b1;
            pend_nxt     = '{conn_out: 4'(idx_r), action: scan_act,
                             retry_count: scan_e.rt, last: 1'b0};
            cnt_nxt      = cnt_r + rtbt_pkg::CNT_W'(1);
          end
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + AW'(1);
            raddr   = idx_nxt;
          end
        end
      end
      rtbt_pkg::ST_FLUSH: begin
        if (pend_vld_r && out_free) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
          pend_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rtbt_pkg::ST_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    conn_r <= conn_nxt;
    sbe_r  <= sbe_nxt;
    inr_r  <= inr_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_s.valid       = out_vld_r;
  assign out_s.conn_out    = out_r.conn_out;
  assign out_s.action      = out_r.action;
  assign out_s.retry_count = out_r.retry_count;
  assign out_s.last        = out_r.last;

endmodule

`default_nettype wire

@@ hdl/retransmit_timer_backoff_table.sv @@
// Retransmission timer table with exponential backoff, one timer per connection.
// Input channel in_s (valid/ready): one command word = operation, conn,
//   send_buffer_empty. Operations: tick, arm, ack update, disarm.
// Output channel out_s (valid/ready): result words conn_out, action,
//   retry_count, last. Arm, ack update and disarm give exactly one word; a tick
//   gives one word per expired timer in ascending connection order (at most 16,
//   last set on the final one) and no word when nothing expires.
// Config port cfg_we/cfg_index/cfg_data: 0 initial_interval, 1 scan_step,
//   2 max_retries; write only while the block is idle.
// Timing: a control word is accepted, then the entry memory is read-modify-written
//   once the output register is free, and its result is valid the cycle after. In a
//   tick the scan reads the next entry and writes back the current enabled one each
//   cycle unless stalled, through the memory's separate read and write ports,
//   then the held final result is sent.
// A stalled receiver holds the output register; the sequencer waits only when it
//   has a new word to place there, so one word of slack is always absorbed.
// Reset (rst_n, synchronous) restores register defaults and marks every entry
//   as unwritten, so all timers read as disabled with zero retries at once.
`default_nettype none

module retransmit_timer_backoff_table #(
  parameter int NUM_CONN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rtbt_in_if.sink          in_s,
  rtbt_out_if.source       out_s,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  // address width into the entry memory; at least one bit
  localparam int AW = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;

  rtbt_pkg::cfg_t   cfg;
  rtbt_pkg::entry_t rdata;
  rtbt_pkg::entry_t wdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             we;

  rtbt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // entry store: enable, remaining time, retry count
  rtbt_mem #(.NUM_CONN(NUM_CONN), .AW(AW)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  // sequencer, update datapath and output register
  rtbt_ctrl #(.NUM_CONN(NUM_CONN), .AW(AW)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .out_s (out_s),
    .cfg   (cfg),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

endmodule

`default_nettype wire
